// ===== rtl/bnv_pkg.sv =====
// Shared constants, codes and types of the BGR to NV21 converter.
package bnv_pkg;

  localparam int COMP_W       = 8;
  localparam int BYTE_W       = 8;
  localparam int DIM_W        = 13;
  localparam int COEF_W       = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int KIND_W       = 2;
  localparam int BUF_IDX_W    = 25;
  localparam int LUMA_IDX_W   = 24;
  localparam int CHROMA_IDX_W = 23;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int FRAC_BITS_DEF  = 14;

  localparam logic [DIM_W-1:0]  WIDTH_RST       = DIM_W'(640);
  localparam logic [DIM_W-1:0]  HEIGHT_RST      = DIM_W'(480);
  localparam logic [COEF_W-1:0] COEF_B_LUMA_RST = COEF_W'(1868);
  localparam logic [COEF_W-1:0] COEF_G_LUMA_RST = COEF_W'(9617);
  localparam logic [COEF_W-1:0] COEF_R_LUMA_RST = COEF_W'(4899);
  localparam logic [COEF_W-1:0] COEF_B_DIFF_RST = COEF_W'(9241);
  localparam logic [COEF_W-1:0] COEF_R_DIFF_RST = COEF_W'(11682);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_COEF_BLUE_LUMA,
    REG_COEF_GREEN_LUMA,
    REG_COEF_RED_LUMA,
    REG_COEF_BLUE_DIFF,
    REG_COEF_RED_DIFF
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LUMA,
    KIND_V,
    KIND_U
  } sample_kind_t;

  typedef struct packed {
    logic                  chroma;
    logic [LUMA_IDX_W-1:0] luma_idx;
    logic [BUF_IDX_W-1:0]  vu_idx;
  } pix_meta_t;

endpackage

// ===== rtl/bnv_pixel_if.sv =====
// Pixel input channel: one BGR pixel per beat.
interface bnv_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [bnv_pkg::COMP_W-1:0]  blue;
  logic [bnv_pkg::COMP_W-1:0]  green;
  logic [bnv_pkg::COMP_W-1:0]  red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

// ===== rtl/bnv_sample_if.sv =====
// Sample output channel: one NV21 byte with its buffer offset per beat.
interface bnv_sample_if;
  logic                          valid;
  logic                          ready;
  logic [bnv_pkg::KIND_W-1:0]    sample_kind;
  logic [bnv_pkg::BYTE_W-1:0]    sample_value;
  logic [bnv_pkg::BUF_IDX_W-1:0] buffer_index;
  logic                          last_of_pixel;

  modport source (output valid, output sample_kind, output sample_value,
                  output buffer_index, output last_of_pixel, input ready);
  modport sink   (input valid, input sample_kind, input sample_value,
                  input buffer_index, input last_of_pixel, output ready);
endinterface

// ===== rtl/bgr_to_nv21_converter_core.sv =====
// BGR to NV21 converter: the whole datapath, counters and configuration registers.
//
// Usage:
//   pixel_in takes one BGR pixel per beat in raster order. sample_out gives a luma
//   byte for every pixel and, for pixels at an even row and even column, a V byte
//   and then a U byte; each beat carries its offset in the NV21 buffer and
//   last_of_pixel flags the final beat of a pixel.
//   The user writes configuration (cfg_write/cfg_index/cfg_data) while the block is idle;
//   the block does not enforce this. With an odd or out-of-range width or height,
//   pixels are taken and dropped.
// Timing:
//   Three register stages (input, luma, chroma/result); the luma beat of a pixel is
//   offered once the pixel reaches the result register. A pixel is taken every cycle
//   while the stages ahead are free; the result register emits one beat per cycle
//   while sample_out.ready is high, holding a chroma pixel for its luma, V and U beats
//   and a luma-only pixel for its luma beat alone, so the single output port sets the pace.
// Reset and stalls:
//   rst clears the counters and buffer offsets and restores the default geometry
//   (640x480) and coefficients. While sample_out is stalled the result register
//   holds; the two earlier stages still fill, then pixel_in.ready drops.
module bgr_to_nv21_converter_core #(
  parameter int MAX_WIDTH  = bnv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bnv_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bnv_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bnv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bnv_pkg::CFG_DATA_W-1:0]   cfg_data,
  bnv_pixel_if.sink                        pixel_in,
  bnv_sample_if.source                     sample_out
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int PROD_W = bnv_pkg::COMP_W + bnv_pkg::COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int LUMA_W = SUM_W - FRAC_BITS;
  localparam int DIFF_W = LUMA_W + 1;
  localparam int CH_W   = DIFF_W + bnv_pkg::COEF_W + 2;
  localparam int DW     = bnv_pkg::DIM_W;
  localparam int BW     = bnv_pkg::BYTE_W;
  localparam int IW     = bnv_pkg::BUF_IDX_W;

  localparam logic signed [CH_W-1:0] CH_OFFSET = CH_W'(128) <<< FRAC_BITS;

  // configuration
  logic [DW-1:0]                  image_width;
  logic [DW-1:0]                  image_height;
  logic [bnv_pkg::COEF_W-1:0]     coef_blue_luma;
  logic [bnv_pkg::COEF_W-1:0]     coef_green_luma;
  logic [bnv_pkg::COEF_W-1:0]     coef_red_luma;
  logic [bnv_pkg::COEF_W-1:0]     coef_blue_diff;
  logic [bnv_pkg::COEF_W-1:0]     coef_red_diff;

  logic                           geom_ok;
  logic [IW-1:0]                  plane;
  logic [2*DW-1:0]                area;

  // raster position
  logic [COL_W-1:0]                    col_count;
  logic [ROW_W-1:0]                    row_count;
  logic [bnv_pkg::LUMA_IDX_W-1:0]      luma_index;
  logic [bnv_pkg::CHROMA_IDX_W-1:0]    chroma_index;
  logic                                col_end;
  logic                                row_end;
  logic                                frame_end;
  logic                                chroma_here;

  // pipeline
  logic                           in_fire;
  logic                           take;
  logic                           a_free;
  logic                           b_free;
  logic                           c_free;
  logic                           out_fire;
  logic                           out_last;

  logic                           a_v;
  logic [bnv_pkg::COMP_W-1:0]     a_b;
  logic [bnv_pkg::COMP_W-1:0]     a_g;
  logic [bnv_pkg::COMP_W-1:0]     a_r;
  bnv_pkg::pix_meta_t             a_meta;

  logic [SUM_W-1:0]               luma_sum;
  logic [LUMA_W-1:0]              luma_full;

  logic                           b_v;
  logic [LUMA_W-1:0]              b_luma;
  logic [BW-1:0]                  b_y;
  logic [bnv_pkg::COMP_W-1:0]     b_b;
  logic [bnv_pkg::COMP_W-1:0]     b_r;
  bnv_pkg::pix_meta_t             b_meta;

  logic signed [DIFF_W-1:0]       diff_v;
  logic signed [DIFF_W-1:0]       diff_u;
  logic signed [bnv_pkg::COEF_W:0] coef_vs;
  logic signed [bnv_pkg::COEF_W:0] coef_us;
  logic signed [CH_W-1:0]         sum_v;
  logic signed [CH_W-1:0]         sum_u;

  logic                           c_v;
  logic [BW-1:0]                  c_y;
  logic [BW-1:0]                  c_vb;
  logic [BW-1:0]                  c_ub;
  bnv_pkg::pix_meta_t             c_meta;
  bnv_pkg::sample_kind_t          c_beat;
  bnv_pkg::sample_kind_t          c_beat_next;

  function automatic logic [BW-1:0] clamp_chroma(input logic signed [CH_W-1:0] s);
    logic [CH_W-2-FRAC_BITS:0] hi;
    hi = s[CH_W-2:FRAC_BITS];
    if (s[CH_W-1]) begin
      return '0;
    end else if (|hi[CH_W-2-FRAC_BITS:BW]) begin
      return '1;
    end
    return hi[BW-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= bnv_pkg::WIDTH_RST;
      image_height    <= bnv_pkg::HEIGHT_RST;
      coef_blue_luma  <= bnv_pkg::COEF_B_LUMA_RST;
      coef_green_luma <= bnv_pkg::COEF_G_LUMA_RST;
      coef_red_luma   <= bnv_pkg::COEF_R_LUMA_RST;
      coef_blue_diff  <= bnv_pkg::COEF_B_DIFF_RST;
      coef_red_diff   <= bnv_pkg::COEF_R_DIFF_RST;
    end else if (cfg_write) begin
      unique case (bnv_pkg::cfg_reg_t'(cfg_index))
        bnv_pkg::REG_IMAGE_WIDTH:     image_width     <= cfg_data[DW-1:0];
        bnv_pkg::REG_IMAGE_HEIGHT:    image_height    <= cfg_data[DW-1:0];
        bnv_pkg::REG_COEF_BLUE_LUMA:  coef_blue_luma  <= cfg_data;
        bnv_pkg::REG_COEF_GREEN_LUMA: coef_green_luma <= cfg_data;
        bnv_pkg::REG_COEF_RED_LUMA:   coef_red_luma   <= cfg_data;
        bnv_pkg::REG_COEF_BLUE_DIFF:  coef_blue_diff  <= cfg_data;
        bnv_pkg::REG_COEF_RED_DIFF:   coef_red_diff   <= cfg_data;
        default: ;
      endcase
    end
  end

  // geometry check and chroma plane base come straight from the registers
  assign area    = image_width * image_height;
  assign plane   = area[IW-1:0];
  assign geom_ok = !image_width[0] && !image_height[0] &&
                   (image_width >= DW'(2)) && (image_height >= DW'(2)) &&
                   (32'(image_width) <= MAX_WIDTH) &&
                   (32'(image_height) <= MAX_HEIGHT);

  // ---------------------------------------------------------------- handshake
  assign in_fire         = pixel_in.valid && pixel_in.ready;
  assign take            = in_fire && geom_ok;
  assign c_free          = !c_v || (sample_out.ready && out_last);
  assign b_free          = !b_v || c_free;
  assign a_free          = !a_v || b_free;
  assign pixel_in.ready  = a_free;
  assign out_fire        = c_v && sample_out.ready;

  // ---------------------------------------------------------------- raster position
  assign col_end     = DW'(col_count) >= (image_width - DW'(1));
  assign row_end     = DW'(row_count) >= (image_height - DW'(1));
  assign frame_end   = col_end && row_end;
  assign chroma_here = !row_count[0] && !col_count[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count    <= '0;
      row_count    <= '0;
      luma_index   <= '0;
      chroma_index <= '0;
    end else if (take) begin
      if (col_end) begin
        col_count <= '0;
        if (row_end) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + ROW_W'(1);
        end
      end else begin
        col_count <= col_count + COL_W'(1);
      end
      if (frame_end) begin
        luma_index   <= '0;
        chroma_index <= '0;
      end else begin
        luma_index <= luma_index + bnv_pkg::LUMA_IDX_W'(1);
        if (chroma_here) begin
          chroma_index <= chroma_index + bnv_pkg::CHROMA_IDX_W'(2);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage A: input
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_free) begin
      a_v <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_b             <= pixel_in.blue;
      a_g             <= pixel_in.green;
      a_r             <= pixel_in.red;
      a_meta.chroma   <= chroma_here;
      a_meta.luma_idx <= luma_index;
      a_meta.vu_idx   <= plane + IW'(chroma_index);
    end
  end

  // ---------------------------------------------------------------- stage B: luma
  assign luma_sum  = a_b * coef_blue_luma + a_g * coef_green_luma + a_r * coef_red_luma;
  assign luma_full = luma_sum[SUM_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_free) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (a_v && b_free) begin
      b_luma <= luma_full;
      b_y    <= (|luma_full[LUMA_W-1:BW]) ? '1 : luma_full[BW-1:0];
      b_b    <= a_b;
      b_r    <= a_r;
      b_meta <= a_meta;
    end
  end

  // ---------------------------------------------------------------- stage C: chroma, results
  // differences use the unclamped luma
  assign diff_v  = $signed(DIFF_W'(b_r)) - $signed(DIFF_W'(b_luma));
  assign diff_u  = $signed(DIFF_W'(b_b)) - $signed(DIFF_W'(b_luma));
  assign coef_vs = $signed({1'b0, coef_red_diff});
  assign coef_us = $signed({1'b0, coef_blue_diff});
  assign sum_v   = diff_v * coef_vs + CH_OFFSET;
  assign sum_u   = diff_u * coef_us + CH_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (c_free) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_v && c_free) begin
      c_y    <= b_y;
      c_vb   <= clamp_chroma(sum_v);
      c_ub   <= clamp_chroma(sum_u);
      c_meta <= b_meta;
    end
  end

  always_comb begin
    unique case (c_beat)
      bnv_pkg::KIND_LUMA: c_beat_next = bnv_pkg::KIND_V;
      bnv_pkg::KIND_V:    c_beat_next = bnv_pkg::KIND_U;
      default:            c_beat_next = bnv_pkg::KIND_LUMA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_beat <= bnv_pkg::KIND_LUMA;
    end else if (out_fire) begin
      c_beat <= out_last ? bnv_pkg::KIND_LUMA : c_beat_next;
    end
  end

  always_comb begin
    sample_out.valid       = c_v;
    sample_out.sample_kind = c_beat;
    unique case (c_beat)
      bnv_pkg::KIND_V: begin
        sample_out.sample_value = c_vb;
        sample_out.buffer_index = c_meta.vu_idx;
        out_last                = 1'b0;
      end
      bnv_pkg::KIND_U: begin
        // V offset is always even, so U sits at the odd neighbour
        sample_out.sample_value = c_ub;
        sample_out.buffer_index = {c_meta.vu_idx[IW-1:1], 1'b1};
        out_last                = 1'b1;
      end
      default: begin
        sample_out.sample_value = c_y;
        sample_out.buffer_index = IW'(c_meta.luma_idx);
        out_last                = !c_meta.chroma;
      end
    endcase
    sample_out.last_of_pixel = out_last;
  end

`ifndef NO_ASSERTIONS
  chroma_beat_only_on_chroma_pixel: assert property (@(posedge clk) disable iff (rst)
    (c_v && (c_beat != bnv_pkg::KIND_LUMA)) |-> c_meta.chroma)
    else $error("chroma beat on a pixel without chroma");

  bad_geometry_keeps_position: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !geom_ok) |=> ($stable(col_count) && $stable(row_count) &&
                               $stable(luma_index) && $stable(chroma_index)))
    else $error("dropped pixel moved the raster position");

  last_beat_rewinds: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_last) |=> (c_beat == bnv_pkg::KIND_LUMA))
    else $error("beat counter not rewound after last beat of pixel");

  result_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (c_v && !sample_out.ready) |=> (c_v && $stable(c_beat) && $stable(c_meta)))
    else $error("result stage changed while stalled");
`endif

endmodule
